// ===== sv/mbps_pkg.sv =====
// Package for the masked byte pattern search block.
// Shared constants, register index codes and the result record.
// No dependencies.
package mbps_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int PAT_BYTES  = 16;   // pattern bytes held in the two config words
  localparam int PAT_IDX_W  = 4;    // index into the pattern bytes
  localparam int PLEN_W     = 5;    // pattern length register
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int OFF_OUT_W  = 32;   // match_offset port width

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LEN    = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 found;
    logic [OFF_OUT_W-1:0] offset;
  } result_t;

endpackage

// ===== sv/mbps_cell.sv =====
// One window cell: holds one buffer byte and compares it with the pattern
// byte that lines up with its age. Depends on mbps_pkg.
module mbps_cell #(
  parameter int AGE = 0
) (
  input  logic                                   clk,
  input  logic                                   shift_en,
  input  logic [7:0]                             data_in,
  input  logic [8*mbps_pkg::PAT_BYTES-1:0]       pattern,
  input  logic [mbps_pkg::PAT_BYTES-1:0]         care,
  input  logic [mbps_pkg::PLEN_W-1:0]            len_act,
  output logic [7:0]                             data_out,
  output logic                                   ok
);
  import mbps_pkg::*;

  logic [7:0]           byte_r;
  logic                 covered;
  logic [PLEN_W-1:0]    pos;
  logic [PAT_IDX_W-1:0] idx;
  logic                 pos_cares;

  // Window bytes need no reset: a compare only counts once the buffer
  // has filled every covered cell.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= data_in;
    end
  end

  assign data_out = byte_r;

  // Compare runs on the byte entering this cell, i.e. the post-shift window.
  always_comb begin
    covered   = (int'(len_act) > AGE);
    pos       = len_act - PLEN_W'(AGE + 1);
    idx       = pos[PAT_IDX_W-1:0];
    pos_cares = (int'(pos) < PAT_BYTES) && care[idx];
    ok        = !covered || !pos_cares || (data_in == pattern[8*idx +: 8]);
  end

endmodule

// ===== sv/mbps_out_buf.sv =====
// Result output register with a skid entry behind it.
// Depends on mbps_pkg.
module mbps_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mbps_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mbps_pkg::result_t out_data
);
  import mbps_pkg::*;

  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  logic    take;

  assign take = out_v_r && !out_stall;

  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      // producer is stalled while the skid entry is occupied
      if (take) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || take) begin
        out_nxt   = push_data;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== sv/masked_byte_pattern_search_top.sv =====
// Masked byte pattern search, top level: config registers, cell chain,
// byte counter and result buffer. Depends on mbps_pkg, mbps_cell, mbps_out_buf.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | in_data_byte, in_last_byte
//   out_    | out | out_valid/out_stall| out_found, out_match_offset
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_stall is low; the window compare across
// the cell chain is done in the cycle the byte is accepted, and the result is
// registered in the output register, or in its skid entry behind a stall.
// in_stall rises only when both the output register and its skid entry hold
// results. cfg_ready is always high. Reset is synchronous and active low; no
// clearing pass is needed.
module masked_byte_pattern_search_top #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [mbps_pkg::OFF_OUT_W-1:0]  out_match_offset,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbps_pkg::*;

  logic [CFG_DATA_W-1:0]  pat_lo_r, pat_hi_r;
  logic [PAT_BYTES-1:0]   care_r;
  logic [PLEN_W-1:0]      len_r;
  logic [PLEN_W-1:0]      len_act;

  logic [OFFSET_BITS-1:0] byte_count_r, byte_count_nxt;
  logic                   match_seen_r, match_seen_nxt;

  logic [7:0]             win   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_ok;

  logic                   accept, shift_en, counted, hit, res_push, buf_full;
  logic [OFFSET_BITS-1:0] cnt_inc, len_ext, offset_full;
  result_t                res, out_res;

  // config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '0;
      len_r    <= PLEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAT_LO: pat_lo_r <= cfg_wdata;
        REG_PAT_HI: pat_hi_r <= cfg_wdata;
        REG_CARE:   care_r   <= cfg_wdata[PAT_BYTES-1:0];
        REG_LEN:    len_r    <= cfg_wdata[PLEN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      len_act = PLEN_W'(1);
    end else if (int'(len_r) > MAX_PATTERN) begin
      len_act = PLEN_W'(MAX_PATTERN);
    end else begin
      len_act = len_r;
    end
  end

  assign accept   = in_valid && !in_stall;
  assign shift_en = accept && !match_seen_r;

  // window chain, newest byte in cell 0
  for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
    logic [7:0] cell_in;
    if (a == 0) begin : g_head
      assign cell_in = in_data_byte;
    end else begin : g_link
      assign cell_in = win[a-1];
    end
    mbps_cell #(
      .AGE (a)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .data_in  (cell_in),
      .pattern  ({pat_hi_r, pat_lo_r}),
      .care     (care_r),
      .len_act  (len_act),
      .data_out (win[a]),
      .ok       (cell_ok[a])
    );
  end

  // counter saturates; bytes taken while full cannot complete a match
  assign counted     = (byte_count_r != '1);
  assign cnt_inc     = byte_count_r + OFFSET_BITS'(1);
  assign len_ext     = OFFSET_BITS'(len_act);
  assign offset_full = cnt_inc - len_ext;
  assign hit         = shift_en && counted && (cnt_inc >= len_ext) && (&cell_ok);
  assign res_push    = hit || (accept && in_last_byte && !match_seen_r);

  always_comb begin
    res.found  = hit;
    res.offset = hit ? OFF_OUT_W'(offset_full) : '0;
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    match_seen_nxt = match_seen_r;
    if (accept) begin
      if (in_last_byte) begin
        byte_count_nxt = '0;
        match_seen_nxt = 1'b0;
      end else begin
        if (shift_en && counted) begin
          byte_count_nxt = cnt_inc;
        end
        if (hit) begin
          match_seen_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      match_seen_r <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      match_seen_r <= match_seen_nxt;
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign in_stall         = buf_full;
  assign out_found        = out_res.found;
  assign out_match_offset = out_res.offset;

endmodule

// ===== sv/mbps_checker.sv =====
// Port-level checker for the masked byte pattern search top level,
// bound to it below. Depends on mbps_pkg.
module mbps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_found,
  input logic [mbps_pkg::OFF_OUT_W-1:0] out_match_offset
);
  import mbps_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found)
      && $stable(out_match_offset))
    else $error("stalled result changed");

  // a no-match report carries a zero offset
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == '0)
    else $error("no-match result with nonzero offset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output backpressure");

  // while input is held off a result is on offer
  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind masked_byte_pattern_search_top mbps_checker u_mbps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_match_offset (out_match_offset)
);
